/* src/ptsch_pkg.sv */
// shared types, codes and defaults for the priority task scheduler
package ptsch_pkg;

	localparam int NUM_TASKS_DEF = 16;
	localparam int TICK_BITS_DEF = 16;

	localparam int ACTION_W = 3;
	localparam int TASK_W   = 4;
	localparam int TICKS_W  = 16;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 8;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_READY = 2'd1,
		ST_SUSP  = 2'd2,
		ST_SLEEP = 2'd3
	} slot_state_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CREATE  = 3'd0,
		ACT_SUSPEND = 3'd1,
		ACT_RESUME  = 3'd2,
		ACT_SLEEP   = 3'd3,
		ACT_TICK    = 3'd4
	} action_t;

	typedef struct packed {
		logic        tick;
		logic        hit_t;
		slot_state_t t_state;
		logic        t_clr;
		logic        hit_c;
		slot_state_t c_state;
		logic        c_load;
	} upd_ctl_t;

endpackage

/* src/priority_task_scheduler.sv */
// fixed-priority task scheduler with the task table held in a ram
// per item: two lookups in the table ram, then a walk over it with one entry read,
//   updated and written per cycle, then the result in S_FIN; a new item is taken
//   only back in S_IDLE, after the result of the last one has been registered
// reset: control state and per-entry valid bits clear at once; an entry not
//   yet written reads as empty with count zero, so no clearing pass is needed
module priority_task_scheduler #(
	parameter int NUM_TASKS = ptsch_pkg::NUM_TASKS_DEF,
	parameter int TICK_BITS = ptsch_pkg::TICK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// task_req[3:0], ticks[19:4], in_isr[20], zero pad
	input  logic [ptsch_pkg::S_TDATA_W-1:0] s_tdata,
	// action[2:0]
	input  logic [ptsch_pkg::ACTION_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// run_task[3:0], run_valid[4], switched[5], accepted[6], zero pad
	output logic [ptsch_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int IW = $clog2(NUM_TASKS);
	localparam int EW = TICK_BITS + 2;
	localparam logic [31:0] TMAX = 32'((64'd1 << TICK_BITS) - 64'd1);
	localparam logic [IW-1:0] LAST = IW'(NUM_TASKS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_T,
		S_RD_C,
		S_WALK,
		S_FIN
	} fsm_t;

	fsm_t state_q;

	logic [IW-1:0]        t_q;
	logic                 inr_q;
	logic                 isr_q;
	ptsch_pkg::action_t   act_q;
	logic [TICK_BITS-1:0] sat_q;

	logic [IW-1:0] cur_q;
	logic          cv_q;
	logic [IW-1:0] pend_q;

	ptsch_pkg::slot_state_t st_t_q;

	logic                   acc_q;
	logic                   sched_q;
	logic                   wr_t_q;
	ptsch_pkg::slot_state_t t_state_q;
	logic                   t_clr_q;
	logic                   wr_c_q;
	ptsch_pkg::slot_state_t c_state_q;
	logic                   c_load_q;
	logic                   tick_q;
	logic [IW-1:0]          pend_base_q;

	logic          found_q;
	logic [IW-1:0] first_q;
	logic          moved_q;
	logic [IW-1:0] pend_w_q;
	logic          cap_q;

	logic [NUM_TASKS-1:0] vld_q;
	logic                 ent_vld_s1;
	logic [IW-1:0]        ridx_s1;

	logic                       m_tvalid_q;
	logic [ptsch_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [31:0]   t32;
	logic          in_rng;
	logic [IW-1:0] t_idx;
	logic [31:0]   tk32;
	logic [TICK_BITS-1:0] sat;

	logic [IW-1:0] raddr;
	logic [EW-1:0] rdata;
	logic [EW-1:0] wdata;

	ptsch_pkg::slot_state_t eff_state;
	logic [TICK_BITS-1:0]   eff_count;

	logic                   d_acc;
	logic                   d_sched;
	logic                   d_wr_t;
	ptsch_pkg::slot_state_t d_t_state;
	logic                   d_t_clr;
	logic                   d_wr_c;
	ptsch_pkg::slot_state_t d_c_state;
	logic                   d_c_load;
	logic                   d_tick;
	logic [IW-1:0]          d_pend_base;

	ptsch_pkg::upd_ctl_t    ctl;
	ptsch_pkg::slot_state_t new_state;
	logic [TICK_BITS-1:0]   new_count;
	logic                   woken;

	logic [IW-1:0] pend_new;
	logic          rv;
	logic          sw;
	logic [31:0]   p32;

	assign t32    = 32'(s_tdata[3:0]);
	assign in_rng = t32 < NUM_TASKS;
	assign t_idx  = in_rng ? t32[IW-1:0] : '0;
	assign tk32   = 32'(s_tdata[19:4]);
	assign sat    = (tk32 > TMAX) ? TMAX[TICK_BITS-1:0] : tk32[TICK_BITS-1:0];

	always_comb begin
		unique case (state_q)
			S_IDLE:  raddr = t_idx;
			S_RD_T:  raddr = cur_q;
			S_RD_C:  raddr = '0;
			S_WALK:  raddr = (ridx_s1 == LAST) ? '0 : ridx_s1 + IW'(1);
			default: raddr = '0;
		endcase
	end

	ptsch_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_TASKS)
	) u_table (
		.clk  (clk),
		.we   (state_q == S_WALK),
		.waddr(ridx_s1),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign eff_state = ent_vld_s1 ? ptsch_pkg::slot_state_t'(rdata[1:0]) : ptsch_pkg::ST_EMPTY;
	assign eff_count = ent_vld_s1 ? rdata[EW-1:2] : '0;

	always_comb begin
		d_acc       = 1'b0;
		d_sched     = 1'b0;
		d_wr_t      = 1'b0;
		d_t_state   = ptsch_pkg::ST_READY;
		d_t_clr     = 1'b0;
		d_wr_c      = 1'b0;
		d_c_state   = ptsch_pkg::ST_READY;
		d_c_load    = 1'b0;
		d_tick      = 1'b0;
		d_pend_base = pend_q;
		unique case (act_q)
			ptsch_pkg::ACT_CREATE: begin
				d_acc = inr_q && st_t_q == ptsch_pkg::ST_EMPTY;
				if (d_acc) begin
					d_wr_t  = 1'b1;
					d_t_clr = 1'b1;
					if (!cv_q || t_q < cur_q) begin
						d_sched = 1'b1;
						d_wr_c  = cv_q;
					end
				end
			end
			ptsch_pkg::ACT_SUSPEND: begin
				d_acc = inr_q && st_t_q != ptsch_pkg::ST_EMPTY;
				if (d_acc) begin
					d_wr_c    = cv_q && eff_state != ptsch_pkg::ST_EMPTY;
					d_wr_t    = 1'b1;
					d_t_state = ptsch_pkg::ST_SUSP;
					d_sched   = 1'b1;
				end
			end
			ptsch_pkg::ACT_RESUME: begin
				d_acc = inr_q && st_t_q != ptsch_pkg::ST_EMPTY;
				if (d_acc && st_t_q == ptsch_pkg::ST_SUSP) begin
					d_wr_t  = 1'b1;
					d_t_clr = 1'b1;
					if (!cv_q || t_q < cur_q) begin
						d_wr_c = cv_q && eff_state != ptsch_pkg::ST_EMPTY;
						if (isr_q) begin
							d_pend_base = t_q;
						end else begin
							d_sched = 1'b1;
						end
					end
				end
			end
			ptsch_pkg::ACT_SLEEP: begin
				d_acc   = 1'b1;
				d_sched = 1'b1;
				d_wr_c  = cv_q && eff_state != ptsch_pkg::ST_EMPTY;
				if (sat_q != '0) begin
					d_c_state = ptsch_pkg::ST_SLEEP;
					d_c_load  = 1'b1;
				end
			end
			ptsch_pkg::ACT_TICK: begin
				d_acc  = 1'b1;
				d_tick = 1'b1;
			end
			default: begin
				d_acc = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctl.tick    = tick_q;
		ctl.hit_t   = wr_t_q && ridx_s1 == t_q;
		ctl.t_state = t_state_q;
		ctl.t_clr   = t_clr_q;
		ctl.hit_c   = wr_c_q && ridx_s1 == cur_q;
		ctl.c_state = c_state_q;
		ctl.c_load  = c_load_q;
	end

	ptsch_slot_upd #(
		.TICK_BITS(TICK_BITS)
	) u_upd (
		.state_in (eff_state),
		.count_in (eff_count),
		.ctl      (ctl),
		.load_val (sat_q),
		.state_out(new_state),
		.count_out(new_count),
		.woken    (woken)
	);

	assign wdata = {new_count, new_state};

	always_comb begin
		if (sched_q) begin
			pend_new = found_q ? first_q : pend_q;
			rv       = found_q;
		end else begin
			pend_new = moved_q ? pend_w_q : pend_base_q;
			rv       = moved_q || cap_q;
		end
		sw  = rv && (!cv_q || pend_new != cur_q);
		p32 = 32'(pend_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= '0;
			cv_q       <= 1'b0;
			pend_q     <= '0;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			ent_vld_s1 <= vld_q[raddr];
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						t_q     <= t_idx;
						inr_q   <= in_rng;
						isr_q   <= s_tdata[20];
						act_q   <= ptsch_pkg::action_t'(s_tuser);
						sat_q   <= sat;
						state_q <= S_RD_T;
					end
				end
				S_RD_T: begin
					st_t_q  <= eff_state;
					state_q <= S_RD_C;
				end
				S_RD_C: begin
					acc_q       <= d_acc;
					sched_q     <= d_sched;
					wr_t_q      <= d_wr_t;
					t_state_q   <= d_t_state;
					t_clr_q     <= d_t_clr;
					wr_c_q      <= d_wr_c;
					c_state_q   <= d_c_state;
					c_load_q    <= d_c_load;
					tick_q      <= d_tick;
					pend_base_q <= d_pend_base;
					found_q     <= 1'b0;
					moved_q     <= 1'b0;
					cap_q       <= 1'b0;
					ridx_s1     <= '0;
					state_q     <= S_WALK;
				end
				S_WALK: begin
					vld_q[ridx_s1] <= 1'b1;
					if (!found_q && new_state == ptsch_pkg::ST_READY) begin
						found_q <= 1'b1;
						first_q <= ridx_s1;
					end
					if (woken && !moved_q && ridx_s1 < pend_q) begin
						moved_q  <= 1'b1;
						pend_w_q <= ridx_s1;
					end
					if (ridx_s1 == pend_base_q && new_state == ptsch_pkg::ST_READY) begin
						cap_q <= 1'b1;
					end
					if (ridx_s1 == LAST) begin
						state_q <= S_FIN;
					end else begin
						ridx_s1 <= ridx_s1 + IW'(1);
					end
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, acc_q, sw, rv, p32[3:0]};
						pend_q     <= pend_new;
						if (sched_q) begin
							cv_q <= found_q;
							if (found_q) begin
								cur_q <= first_q;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* src/ptsch_ram.sv */
// generic single-port-write ram with registered read
module ptsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/ptsch_slot_upd.sv */
// update of one task table entry during the table walk
module ptsch_slot_upd #(
	parameter int TICK_BITS = ptsch_pkg::TICK_BITS_DEF
) (
	input  ptsch_pkg::slot_state_t state_in,
	input  logic [TICK_BITS-1:0]   count_in,
	input  ptsch_pkg::upd_ctl_t    ctl,
	input  logic [TICK_BITS-1:0]   load_val,
	output ptsch_pkg::slot_state_t state_out,
	output logic [TICK_BITS-1:0]   count_out,
	output logic                   woken
);

	logic [TICK_BITS-1:0] dec;

	always_comb begin
		dec       = (count_in != '0) ? count_in - TICK_BITS'(1) : '0;
		state_out = state_in;
		count_out = count_in;
		woken     = 1'b0;
		priority if (ctl.hit_t) begin
			state_out = ctl.t_state;
			if (ctl.t_clr) begin
				count_out = '0;
			end
		end else if (ctl.hit_c) begin
			state_out = ctl.c_state;
			if (ctl.c_load) begin
				count_out = load_val;
			end
		end else if (ctl.tick && state_in == ptsch_pkg::ST_SLEEP) begin
			count_out = dec;
			if (dec == '0) begin
				state_out = ptsch_pkg::ST_READY;
				woken     = 1'b1;
			end
		end
	end

endmodule

/* src/ptsch_checker.sv */
// port-level checks for the priority task scheduler, bound to the top level
module ptsch_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [ptsch_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [ptsch_pkg::ACTION_W-1:0]  s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ptsch_pkg::M_TDATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_sw_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[5] && !m_tdata[4]))
		else $error("switch flagged without a selected task");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again while the table walk runs");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared right after an input item");

endmodule

bind priority_task_scheduler ptsch_checker u_ptsch_checker (.*);
